// ===== rtl/polygon_face_centroid_area_normal_assert.svh =====
`ifndef POLYGON_FACE_CENTROID_AREA_NORMAL_ASSERT_SVH
`define POLYGON_FACE_CENTROID_AREA_NORMAL_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define PFCAN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pfcan assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define PFCAN_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pfcan assertion failed");

`endif

// ===== rtl/pfcan_pkg.sv =====
package pfcan_pkg;

  localparam int COORD_W   = 32;
  localparam int SUM_W     = 40;
  localparam int AREA_W    = 48;
  localparam int UNIT_W    = 16;
  localparam int DIV_NUM_W = 80;
  localparam int DIV_DEN_W = 64;
  localparam int RAD_W     = 128;
  localparam int ROOT_W    = 64;
  localparam int FAN_W     = 72;
  localparam int UNIT_SH   = 15;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [AREA_W-1:0]         area_t;
  typedef logic signed [UNIT_W-1:0]  unit_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_FEW   = 2'd1,
    ERR_MANY  = 2'd2,
    ERR_DEGEN = 2'd3
  } err_t;

endpackage

// ===== rtl/pfcan_ifs.sv =====
interface pfcan_in_if;
  logic              valid;
  logic              ready;
  pfcan_pkg::coord_t coord_x;
  pfcan_pkg::coord_t coord_y;
  pfcan_pkg::coord_t coord_z;
  logic              last_vertex;

  modport source(output valid, coord_x, coord_y, coord_z, last_vertex, input ready);
  modport sink(input valid, coord_x, coord_y, coord_z, last_vertex, output ready);
endinterface

interface pfcan_out_if;
  logic              valid;
  logic              ready;
  pfcan_pkg::coord_t center_x;
  pfcan_pkg::coord_t center_y;
  pfcan_pkg::coord_t center_z;
  pfcan_pkg::area_t  face_area;
  pfcan_pkg::unit_t  normal_x;
  pfcan_pkg::unit_t  normal_y;
  pfcan_pkg::unit_t  normal_z;
  pfcan_pkg::err_t   error_code;

  modport source(output valid, center_x, center_y, center_z, face_area,
                 normal_x, normal_y, normal_z, error_code, input ready);
  modport sink(input valid, center_x, center_y, center_z, face_area,
               normal_x, normal_y, normal_z, error_code, output ready);
endinterface

// ===== rtl/pfcan_div.sv =====
module pfcan_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [pfcan_pkg::DIV_NUM_W-1:0] num,
  input  logic [pfcan_pkg::DIV_DEN_W-1:0] den,
  output logic                            done,
  output logic [pfcan_pkg::DIV_NUM_W-1:0] quo
);
  import pfcan_pkg::*;

  localparam int CW = $clog2(DIV_NUM_W);
  localparam logic [CW-1:0] CNT_LAST = CW'(DIV_NUM_W - 1);

  logic                 busy;
  logic [CW-1:0]        cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  // restoring long division, one quotient bit a cycle
  always_comb begin
    trial = {rem, quo[DIV_NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        rem   <= '0;
        quo   <= num;
        den_q <= den;
      end else if (busy) begin
        rem <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
        quo <= {quo[DIV_NUM_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/pfcan_sqrt.sv =====
module pfcan_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [pfcan_pkg::RAD_W-1:0]  rad,
  output logic                         done,
  output logic [pfcan_pkg::ROOT_W-1:0] root
);
  import pfcan_pkg::*;

  localparam int CW  = $clog2(ROOT_W);
  localparam int REM_W = ROOT_W + 2;
  localparam logic [CW-1:0] CNT_LAST = CW'(ROOT_W - 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [RAD_W-1:0] x;
  logic [REM_W-1:0] rem;
  logic [REM_W+1:0] trem;
  logic [REM_W+1:0] tsub;
  logic [REM_W+1:0] diff;
  logic             ge;

  // digit-by-digit root, two radicand bits a cycle
  always_comb begin
    trem = {rem, x[RAD_W-1 -: 2]};
    tsub = (REM_W+2)'({root, 2'b01});
    diff = trem - tsub;
    ge   = trem >= tsub;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        root <= '0;
        x    <= rad;
      end else if (busy) begin
        rem  <= ge ? diff[REM_W-1:0] : trem[REM_W-1:0];
        root <= {root[ROOT_W-2:0], ge};
        x    <= {x[RAD_W-3:0], 2'b00};
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/polygon_face_centroid_area_normal.sv =====
// vertices are taken one per cycle while the block is idle, one face at a time
// after the last vertex, the block checks the vertex count, then runs three centroid divisions
// on the shared divider, scans every vertex, and per fan triangle reads a vertex, runs 16 multiplier
// steps and a root; three normal divisions on the shared divider follow unless the normal is
// degenerate, and a vertex count error goes straight to the result
// rst (synchronous) empties the face, sums and the result register
module polygon_face_centroid_area_normal #(
  parameter int MAX_POINTS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic clk,
  input  logic rst,
  pfcan_in_if.sink    vtx,
  pfcan_out_if.source res
);
  import pfcan_pkg::*;

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int AW    = $clog2(MAX_POINTS);
  localparam int SH0   = FRAC_BITS + 1;  // area shift, no prescale
  localparam int SH1   = FRAC_BITS - 1;  // area shift, vectors halved
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);
  localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(3);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_CDIV, S_CDIV_W, S_RD, S_RDW, S_SCAN, S_FAN,
    S_MUL, S_SQRT, S_SQRT_W, S_AREA, S_UNIT, S_UNIT_W, S_DONE
  } state_t;

  // what the registered product feeds in the next cycle
  typedef enum logic [2:0] {
    OP_NONE, OP_NV_ADD, OP_NV_SUB, OP_SQ_LO, OP_SQ_MID, OP_SQ_HI
  } mop_t;

  state_t state;

  // face accumulation
  logic signed [SUM_W-1:0] sum_x, sum_y, sum_z;
  logic [CNT_W-1:0]        vertex_count;
  logic                    overflow_seen;
  logic                    in_acc;
  logic                    full;

  // vertex store, x in the low word
  logic [3*COORD_W-1:0] vstore [MAX_POINTS];
  logic [AW-1:0]        rd_addr;
  logic [3*COORD_W-1:0] rd_q;

  // sequencer registers
  logic [1:0]       axis;
  logic [CNT_W-1:0] idx;
  logic             fan_phase;
  logic             big;   // some offset needs the one-bit prescale
  coord_t           center [3];
  coord_t           prev [3];
  coord_t           cur [3];
  logic signed [63:0] nv [3];
  logic signed [63:0] nv_first [3];
  logic [ROOT_W-1:0]  nn_first;
  logic [RAD_W-1:0]   sq_acc;
  logic [FAN_W-1:0]   fan_acc;
  logic [3:0]         mstep;
  logic signed [65:0] prod;
  mop_t               add_op;
  logic [1:0]         add_comp;
  area_t              area_q;
  unit_t              unit_q [3];
  err_t               err_q;

  // result register
  logic   o_valid;
  coord_t o_cx, o_cy, o_cz;
  area_t  o_area;
  unit_t  o_nx, o_ny, o_nz;
  err_t   o_err;

  // shared units
  logic                 div_start, div_done;
  logic [DIV_NUM_W-1:0] div_num, div_quo;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 sq_start, sq_done;
  logic [ROOT_W-1:0]    sq_root;

  assign vtx.ready = (state == S_IDLE);
  assign in_acc    = vtx.valid && vtx.ready;
  assign full      = (vertex_count == CNT_MAX);

  assign res.valid      = o_valid;
  assign res.center_x   = o_cx;
  assign res.center_y   = o_cy;
  assign res.center_z   = o_cz;
  assign res.face_area  = o_area;
  assign res.normal_x   = o_nx;
  assign res.normal_y   = o_ny;
  assign res.normal_z   = o_nz;
  assign res.error_code = o_err;

  always_ff @(posedge clk) begin
    if (in_acc && !full) begin
      vstore[vertex_count[AW-1:0]] <= {vtx.coord_z, vtx.coord_y, vtx.coord_x};
    end
    rd_q <= vstore[rd_addr];
  end

  // division operands: |sum| + n/2 over n for the centroid, |normal| scaled over its length for the unit normal
  logic signed [SUM_W-1:0] sum_sel;
  logic [SUM_W-1:0]        sum_mag;
  logic signed [63:0]      nv_sel;
  logic [63:0]             nv_mag;

  always_comb begin
    case (axis)
      2'd0:    sum_sel = sum_x;
      2'd1:    sum_sel = sum_y;
      default: sum_sel = sum_z;
    endcase
    sum_mag = sum_sel[SUM_W-1] ? -sum_sel : sum_sel;
    nv_sel  = nv_first[axis];
    nv_mag  = nv_sel[63] ? -nv_sel : nv_sel;
    if (state == S_UNIT) begin
      div_num = DIV_NUM_W'({nv_mag, {UNIT_SH{1'b0}}});
      div_den = nn_first;
    end else begin
      div_num = DIV_NUM_W'(sum_mag) + DIV_NUM_W'(vertex_count >> 1);
      div_den = DIV_DEN_W'(vertex_count);
    end
    div_start = (state == S_CDIV) || (state == S_UNIT);
    sq_start  = (state == S_SQRT);
  end

  pfcan_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  pfcan_sqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .start(sq_start),
    .rad  (sq_acc),
    .done (sq_done),
    .root (sq_root)
  );

  // offset of the read vertex from the centroid, and its prescaled form
  logic signed [COORD_W:0] dif  [3];
  logic [COORD_W:0]        dmag [3];
  logic [COORD_W:0]        dsh  [3];
  coord_t                  scaled [3];
  logic [2:0]              big_v;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      dif[j] = {rd_q[COORD_W*j + COORD_W - 1], rd_q[COORD_W*j +: COORD_W]}
             - {center[j][COORD_W-1], center[j]};
      big_v[j] = (dif[j][COORD_W] ^ dif[j][COORD_W-1])
               || (dif[j][COORD_W:COORD_W-1] == 2'b11 && dif[j][COORD_W-2:0] == '0);
      dmag[j] = dif[j][COORD_W] ? -dif[j] : dif[j];
      dsh[j]  = big ? (dmag[j] >> 1) : dmag[j];
      scaled[j] = dif[j][COORD_W] ? -dsh[j][COORD_W-1:0] : dsh[j][COORD_W-1:0];
    end
  end

  // multiplier schedule: six cross products, then three partial squares per axis
  mop_t               sel_op;
  logic [1:0]         sel_comp, sel_a, sel_b;
  logic signed [32:0] ma, mb;
  logic signed [63:0] sq_src;
  logic [63:0]        sq_mag;

  always_comb begin
    sel_op   = OP_NONE;
    sel_comp = 2'd0;
    sel_a    = 2'd0;
    sel_b    = 2'd0;
    case (mstep)
      4'd0:  begin sel_op = OP_NV_ADD; sel_comp = 2'd0; sel_a = 2'd1; sel_b = 2'd2; end
      4'd1:  begin sel_op = OP_NV_SUB; sel_comp = 2'd0; sel_a = 2'd2; sel_b = 2'd1; end
      4'd2:  begin sel_op = OP_NV_ADD; sel_comp = 2'd1; sel_a = 2'd2; sel_b = 2'd0; end
      4'd3:  begin sel_op = OP_NV_SUB; sel_comp = 2'd1; sel_a = 2'd0; sel_b = 2'd2; end
      4'd4:  begin sel_op = OP_NV_ADD; sel_comp = 2'd2; sel_a = 2'd0; sel_b = 2'd1; end
      4'd5:  begin sel_op = OP_NV_SUB; sel_comp = 2'd2; sel_a = 2'd1; sel_b = 2'd0; end
      4'd6:  begin sel_op = OP_SQ_LO;  sel_comp = 2'd0; end
      4'd7:  begin sel_op = OP_SQ_MID; sel_comp = 2'd0; end
      4'd8:  begin sel_op = OP_SQ_HI;  sel_comp = 2'd0; end
      4'd9:  begin sel_op = OP_SQ_LO;  sel_comp = 2'd1; end
      4'd10: begin sel_op = OP_SQ_MID; sel_comp = 2'd1; end
      4'd11: begin sel_op = OP_SQ_HI;  sel_comp = 2'd1; end
      4'd12: begin sel_op = OP_SQ_LO;  sel_comp = 2'd2; end
      4'd13: begin sel_op = OP_SQ_MID; sel_comp = 2'd2; end
      4'd14: begin sel_op = OP_SQ_HI;  sel_comp = 2'd2; end
      default: ;
    endcase
    sq_src = nv[sel_comp];
    sq_mag = sq_src[63] ? -sq_src : sq_src;
    case (sel_op)
      OP_NV_ADD, OP_NV_SUB: begin
        ma = {prev[sel_a][COORD_W-1], prev[sel_a]};
        mb = {cur[sel_b][COORD_W-1], cur[sel_b]};
      end
      OP_SQ_LO: begin
        ma = {1'b0, sq_mag[31:0]};
        mb = {1'b0, sq_mag[31:0]};
      end
      OP_SQ_MID: begin
        ma = {2'b00, sq_mag[62:32]};
        mb = {1'b0, sq_mag[31:0]};
      end
      OP_SQ_HI: begin
        ma = {2'b00, sq_mag[62:32]};
        mb = {2'b00, sq_mag[62:32]};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // area: round half up, then saturate
  logic [FAN_W:0]  area_r0, area_r1, area_pick;
  area_t           area_sat;

  always_comb begin
    area_r0   = ((FAN_W+1)'(fan_acc) + ((FAN_W+1)'(1) << (SH0 - 1))) >> SH0;
    area_r1   = ((FAN_W+1)'(fan_acc) + ((FAN_W+1)'(1) << (SH1 - 1))) >> SH1;
    area_pick = big ? area_r1 : area_r0;
    area_sat  = (area_pick[FAN_W:AREA_W] != '0) ? '1 : area_pick[AREA_W-1:0];
  end

  logic [UNIT_W:0] unit_rnd;
  logic [31:0]     cq;
  assign unit_rnd = ({1'b0, div_quo[UNIT_W-1:0]} + 1'b1) >> 1;
  assign cq       = div_quo[COORD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      o_valid       <= 1'b0;
      sum_x         <= '0;
      sum_y         <= '0;
      sum_z         <= '0;
      vertex_count  <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (o_valid && res.ready) o_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (!full) begin
              sum_x <= sum_x + SUM_W'(vtx.coord_x);
              sum_y <= sum_y + SUM_W'(vtx.coord_y);
              sum_z <= sum_z + SUM_W'(vtx.coord_z);
              vertex_count <= vertex_count + 1'b1;
            end else begin
              overflow_seen <= 1'b1;
            end
            if (vtx.last_vertex) state <= S_CHECK;
          end
        end

        S_CHECK: begin
          // too many wins over too few; both give an all-zero result
          if (overflow_seen || vertex_count < CNT_MIN) begin
            err_q  <= overflow_seen ? ERR_MANY : ERR_FEW;
            area_q <= '0;
            for (int j = 0; j < 3; j++) begin
              center[j] <= '0;
              unit_q[j] <= '0;
            end
            state <= S_DONE;
          end else begin
            axis  <= 2'd0;
            state <= S_CDIV;
          end
        end

        S_CDIV: state <= S_CDIV_W;

        S_CDIV_W: begin
          if (div_done) begin
            center[axis] <= sum_sel[SUM_W-1] ? -cq : cq;
            if (axis == 2'd2) begin
              idx       <= '0;
              big       <= 1'b0;
              fan_phase <= 1'b0;
              state     <= S_RD;
            end else begin
              axis  <= axis + 1'b1;
              state <= S_CDIV;
            end
          end
        end

        S_RD: begin
          // the closing fan edge wraps back to vertex 0
          rd_addr <= (idx == vertex_count) ? '0 : idx[AW-1:0];
          state   <= S_RDW;
        end

        S_RDW: state <= fan_phase ? S_FAN : S_SCAN;

        S_SCAN: begin
          big <= big | (|big_v);
          if (idx == vertex_count - 1'b1) begin
            idx       <= '0;
            fan_phase <= 1'b1;
            fan_acc   <= '0;
          end else begin
            idx <= idx + 1'b1;
          end
          state <= S_RD;
        end

        S_FAN: begin
          for (int j = 0; j < 3; j++) cur[j] <= scaled[j];
          if (idx == '0) begin
            for (int j = 0; j < 3; j++) prev[j] <= scaled[j];
            idx   <= idx + 1'b1;
            state <= S_RD;
          end else begin
            for (int j = 0; j < 3; j++) nv[j] <= '0;
            sq_acc <= '0;
            mstep  <= '0;
            state  <= S_MUL;
          end
        end

        S_MUL: begin
          prod     <= ma * mb;
          add_op   <= sel_op;
          add_comp <= sel_comp;
          if (mstep != '0) begin
            case (add_op)
              OP_NV_ADD, OP_NV_SUB: begin
                for (int j = 0; j < 3; j++) begin
                  if (add_comp == 2'(j)) begin
                    nv[j] <= (add_op == OP_NV_ADD) ? nv[j] + prod[63:0]
                                                   : nv[j] - prod[63:0];
                  end
                end
              end
              OP_SQ_LO:  sq_acc <= sq_acc + RAD_W'(prod[63:0]);
              OP_SQ_MID: sq_acc <= sq_acc + (RAD_W'(prod[63:0]) << 33);
              OP_SQ_HI:  sq_acc <= sq_acc + (RAD_W'(prod[63:0]) << 64);
              default: ;
            endcase
          end
          mstep <= mstep + 1'b1;
          if (mstep == 4'd15) state <= S_SQRT;
        end

        S_SQRT: state <= S_SQRT_W;

        S_SQRT_W: begin
          if (sq_done) begin
            fan_acc <= fan_acc + FAN_W'(sq_root);
            // first triangle spans vertices 0 and 1: it gives the normal
            if (idx == CNT_W'(1)) begin
              for (int j = 0; j < 3; j++) nv_first[j] <= nv[j];
              nn_first <= sq_root;
            end
            for (int j = 0; j < 3; j++) prev[j] <= cur[j];
            if (idx == vertex_count) begin
              state <= S_AREA;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_RD;
            end
          end
        end

        S_AREA: begin
          area_q <= area_sat;
          if (nn_first == '0) begin
            err_q <= ERR_DEGEN;
            for (int j = 0; j < 3; j++) unit_q[j] <= '0;
            state <= S_DONE;
          end else begin
            axis  <= 2'd0;
            state <= S_UNIT;
          end
        end

        S_UNIT: state <= S_UNIT_W;

        S_UNIT_W: begin
          if (div_done) begin
            unit_q[axis] <= nv_sel[63] ? -unit_rnd[UNIT_W-1:0] : unit_rnd[UNIT_W-1:0];
            if (axis == 2'd2) begin
              err_q <= ERR_OK;
              state <= S_DONE;
            end else begin
              axis  <= axis + 1'b1;
              state <= S_UNIT;
            end
          end
        end

        S_DONE: begin
          // hold until the result register is free
          if (!o_valid || res.ready) begin
            o_valid <= 1'b1;
            o_cx    <= center[0];
            o_cy    <= center[1];
            o_cz    <= center[2];
            o_area  <= area_q;
            o_nx    <= unit_q[0];
            o_ny    <= unit_q[1];
            o_nz    <= unit_q[2];
            o_err   <= err_q;
            sum_x         <= '0;
            sum_y         <= '0;
            sum_z         <= '0;
            vertex_count  <= '0;
            overflow_seen <= 1'b0;
            state         <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/pfcan_chk.sv =====
`include "polygon_face_centroid_area_normal_assert.svh"

module pfcan_chk (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 last_vertex,
  input logic                 out_valid,
  input logic                 out_ready,
  input pfcan_pkg::coord_t    center_x,
  input pfcan_pkg::area_t     face_area,
  input pfcan_pkg::unit_t     normal_x,
  input pfcan_pkg::unit_t     normal_y,
  input pfcan_pkg::unit_t     normal_z,
  input pfcan_pkg::err_t      error_code
);
  import pfcan_pkg::*;

  // a stalled result holds
  `PFCAN_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(face_area) && $stable(error_code))

  // closing a face stops intake
  `PFCAN_ASSERT_NXT(a_busy_after_last, in_valid && in_ready && last_vertex, !in_ready)

  // count errors clear the payload; checked on area, center_x and every normal field
  `PFCAN_ASSERT_IMP(a_err_zero, out_valid && (error_code == ERR_FEW || error_code == ERR_MANY), face_area == '0 && center_x == '0 && normal_x == '0 && normal_y == '0 && normal_z == '0)

  // degenerate normal reads as zero
  `PFCAN_ASSERT_IMP(a_degen_zero, out_valid && error_code == ERR_DEGEN, normal_x == '0 && normal_y == '0 && normal_z == '0)

  // unit components stay within one
  `PFCAN_ASSERT_IMP(a_unit_range, out_valid && error_code == ERR_OK, normal_x >= -16'sd16384 && normal_x <= 16'sd16384 && normal_y >= -16'sd16384 && normal_y <= 16'sd16384 && normal_z >= -16'sd16384 && normal_z <= 16'sd16384)
endmodule

bind polygon_face_centroid_area_normal pfcan_chk u_pfcan_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (vtx.valid),
  .in_ready   (vtx.ready),
  .last_vertex(vtx.last_vertex),
  .out_valid  (res.valid),
  .out_ready  (res.ready),
  .center_x   (res.center_x),
  .face_area  (res.face_area),
  .normal_x   (res.normal_x),
  .normal_y   (res.normal_y),
  .normal_z   (res.normal_z),
  .error_code (res.error_code)
);
